/* src/crs_pkg.sv */
// Package for the Catmull-Rom spline evaluator: item types, fixed-point
// widths, operation codes and pipeline stage numbers.
// No dependencies.
package crs_pkg;

  // Field widths
  localparam int COORD_W = 32;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int T_W     = 17;
  localparam int FRAC_W  = 16;

  // Horner accumulator and product widths
  localparam int ACC_W  = 38;
  localparam int PROD_W = ACC_W + T_W + 1;

  // Fixed-point constants
  localparam logic [T_W-1:0]    U_ONE      = 17'd65536;
  localparam logic [CNT_W-1:0]  MIN_POINTS = 7'd4;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Pipeline stage numbers
  localparam int STG_ADDR = 1;
  localparam int STG_RD   = 2;
  localparam int STG_LAST = 10;
  localparam int NUM_STG  = STG_LAST + 1;

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic                      operation;
    logic [IDX_W-1:0]          point_index;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
    logic [T_W-1:0]            param_t;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [IDX_W-1:0]          segment;
  } out_item_t;

  // Load enables of the lane stages
  typedef struct packed {
    logic terms;
    logic mul1;
    logic add1;
    logic mul2;
    logic add2;
    logic mul3;
    logic add3;
  } lane_en_t;

endpackage

/* src/crs_in_if.sv */
// Input channel of the spline evaluator: valid, ready and one input item.
// Depends on crs_pkg.
interface crs_in_if;
  logic              valid;
  logic              ready;
  crs_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/crs_out_if.sv */
// Result channel of the spline evaluator: valid, ready and one result item.
// Depends on crs_pkg.
interface crs_out_if;
  logic               valid;
  logic               ready;
  crs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/catmull_rom_spline_eval.sv */
// Top level of the uniform 3D Catmull-Rom spline evaluator: front end,
// four point-table copies, three coordinate lanes and the merging stage.
// Depends on crs_pkg, crs_in_if, crs_out_if, crs_ram, crs_lane, crs_merge.
//
//   channel  | direction | transfer                     | payload
//   ---------+-----------+------------------------------+-------------------------
//   in_i     | sink      | in_i.valid & in_i.ready      | load point or query t
//   out_o    | source    | out_o.valid & out_o.ready    | pos_x/y/z, segment
//   cfg      | write     | cfg_we_i                     | point_count
//
// One item per cycle sustained while out_o is ready; a query passes stages 0 and 1,
// the table read and the three multiply/round-add Horner steps before its result is
// valid on out_o. Loads write the table as they leave stage 1 and give no result.
// Reset clears the stage valid bits and sets point_count to four; the table
// is not cleared. A stall on out_o fills empty stages first, then holds in_i.
module catmull_rom_spline_eval #(
  parameter int MAX_POINTS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  crs_in_if.sink                      in_i,
  crs_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [crs_pkg::CNT_W-1:0]   cfg_data_i
);

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int PT_W  = 3 * crs_pkg::COORD_W;
  localparam int NTAP  = 4;
  localparam int CW    = crs_pkg::CNT_W;
  localparam int NS    = crs_pkg::NUM_STG;
  localparam int SA    = crs_pkg::STG_ADDR;
  localparam int SR    = crs_pkg::STG_RD;
  localparam int SL    = crs_pkg::STG_LAST;

  // Configuration
  logic [CW-1:0] point_count_q;

  // Pipeline control
  logic [NS-1:0] v_q, v_d, vin, rdy, lv, en;

  // Stage 0: scaled parameter
  logic [CW-1:0]      n0, div0;
  logic [23:0]        s0_d;
  logic               op0_q, wok0_q;
  logic [crs_pkg::IDX_W-1:0] slot0_q;
  logic [PT_W-1:0]    pt0_q;
  logic [23:0]        s0_q;
  logic [CW-1:0]      div0_q;

  // Stage 1: segment, local parameter, neighbour addresses
  logic [CW-1:0]      lim1, seg1_d, i0_d, i2_d, i3_d;
  logic [7:0]         segraw1;
  logic [23:0]        ufull1;
  logic [crs_pkg::T_W-1:0] u1_d;
  logic               op1_q, wok1_q;
  logic [crs_pkg::IDX_W-1:0] slot1_q;
  logic [PT_W-1:0]    pt1_q;
  logic [CW-1:0]      seg1_q;
  logic [crs_pkg::T_W-1:0] u1_q;
  logic [AW-1:0]      addr1_q [NTAP];

  // Table and later stages
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_wa;
  logic [PT_W-1:0]    ram_rd [NTAP];
  logic [crs_pkg::T_W-1:0] u2_q;
  logic [crs_pkg::IDX_W-1:0] segp_q [SR:SL-1];
  crs_pkg::lane_en_t  lane_en;
  crs_pkg::acc_t      acc [3];

  // Point count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= crs_pkg::MIN_POINTS;
    end else if (cfg_we_i) begin
      point_count_q <= cfg_data_i;
    end
  end

  // Valid/ready chain: each stage fills when empty or when it empties
  always_comb begin
    vin = '0;
    vin[0] = in_i.valid;
    for (int k = 1; k < NS; k++) begin
      vin[k] = v_q[k-1];
    end
    vin[SR] = v_q[SA] && (op1_q == crs_pkg::OP_EVAL);
    lv[SL]  = out_o.ready;
    rdy[SL] = !v_q[SL] || lv[SL];
    for (int k = SL - 1; k >= 0; k--) begin
      lv[k]  = ((k == SA) && (op1_q == crs_pkg::OP_LOAD)) ? 1'b1 : rdy[k+1];
      rdy[k] = !v_q[k] || lv[k];
    end
    for (int k = 0; k < NS; k++) begin
      en[k]  = rdy[k] && vin[k];
      v_d[k] = rdy[k] ? vin[k] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_i.ready  = rdy[0];
  assign out_o.valid = v_q[SL];

  // Stage 0: clamp the point count and scale t by (n-1)
  always_comb begin
    if (point_count_q < crs_pkg::MIN_POINTS) begin
      n0 = crs_pkg::MIN_POINTS;
    end else if (int'(point_count_q) > MAX_POINTS) begin
      n0 = CW'(MAX_POINTS);
    end else begin
      n0 = point_count_q;
    end
    div0 = n0 - CW'(1);
    s0_d = {7'b0, in_i.data.param_t} * {17'b0, div0};
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      op0_q   <= in_i.data.operation;
      wok0_q  <= int'(in_i.data.point_index) < MAX_POINTS;
      slot0_q <= in_i.data.point_index;
      pt0_q   <= {in_i.data.in_z, in_i.data.in_y, in_i.data.in_x};
      s0_q    <= s0_d;
      div0_q  <= div0;
    end
  end

  // Stage 1: pick and clamp the segment, local parameter and neighbours
  always_comb begin
    lim1    = div0_q - CW'(1);
    segraw1 = s0_q[23:16];
    seg1_d  = ({1'b0, lim1} < segraw1) ? lim1 : segraw1[CW-1:0];
    ufull1  = s0_q - {1'b0, seg1_d, 16'b0};
    u1_d    = (ufull1 > {7'b0, crs_pkg::U_ONE}) ? crs_pkg::U_ONE
                                                 : ufull1[crs_pkg::T_W-1:0];
    i0_d    = (seg1_d == '0) ? '0 : seg1_d - CW'(1);
    i2_d    = ((seg1_d + CW'(1)) < div0_q) ? seg1_d + CW'(1) : div0_q;
    i3_d    = ((seg1_d + CW'(2)) < div0_q) ? seg1_d + CW'(2) : div0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[SA]) begin
      op1_q      <= op0_q;
      wok1_q     <= wok0_q;
      slot1_q    <= slot0_q;
      pt1_q      <= pt0_q;
      seg1_q     <= seg1_d;
      u1_q       <= u1_d;
      addr1_q[0] <= AW'(i0_d);
      addr1_q[1] <= AW'(seg1_d);
      addr1_q[2] <= AW'(i2_d);
      addr1_q[3] <= AW'(i3_d);
    end
  end

  // Table access as stage 1 drains: loads write, queries read
  assign ram_we = v_q[SA] && (op1_q == crs_pkg::OP_LOAD) && wok1_q;
  assign ram_re = en[SR];
  assign ram_wa = AW'(slot1_q);

  for (genvar g = 0; g < NTAP; g++) begin : g_tap
    crs_ram #(
      .WIDTH (PT_W),
      .DEPTH (MAX_POINTS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i (ram_wa),
      .wdata_i (pt1_q),
      .re_i    (ram_re),
      .raddr_i (addr1_q[g]),
      .rdata_o (ram_rd[g])
    );
  end

  // Carry the local parameter and segment alongside the read data
  always_ff @(posedge clk_i) begin
    if (en[SR]) begin
      u2_q       <= u1_q;
      segp_q[SR] <= seg1_q[crs_pkg::IDX_W-1:0];
    end
    for (int k = SR + 1; k < SL; k++) begin
      if (en[k]) begin
        segp_q[k] <= segp_q[k-1];
      end
    end
  end

  always_comb begin
    lane_en.terms = en[SR+1];
    lane_en.mul1  = en[SR+2];
    lane_en.add1  = en[SR+3];
    lane_en.mul2  = en[SR+4];
    lane_en.add2  = en[SR+5];
    lane_en.mul3  = en[SR+6];
    lane_en.add3  = en[SR+7];
  end

  // One lane per coordinate
  for (genvar c = 0; c < 3; c++) begin : g_lane
    crs_lane u_lane (
      .clk_i (clk_i),
      .en_i  (lane_en),
      .p0_i  ($signed(ram_rd[0][c*crs_pkg::COORD_W +: crs_pkg::COORD_W])),
      .p1_i  ($signed(ram_rd[1][c*crs_pkg::COORD_W +: crs_pkg::COORD_W])),
      .p2_i  ($signed(ram_rd[2][c*crs_pkg::COORD_W +: crs_pkg::COORD_W])),
      .p3_i  ($signed(ram_rd[3][c*crs_pkg::COORD_W +: crs_pkg::COORD_W])),
      .u_i   (u2_q),
      .acc_o (acc[c])
    );
  end

  // Merge the lanes into the result register
  crs_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (en[SL]),
    .acc_x_i (acc[0]),
    .acc_y_i (acc[1]),
    .acc_z_i (acc[2]),
    .seg_i   (segp_q[SL-1]),
    .data_o  (out_o.data)
  );

`ifndef ASSERT_OFF
  // A table write and a table read never share a cycle
  a_ram_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("table write and read in the same cycle");

  // Neighbour addresses of a query are in order
  a_addr_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[SA] && (op1_q == crs_pkg::OP_EVAL)) |->
      (addr1_q[0] <= addr1_q[1]) && (addr1_q[1] <= addr1_q[2]) &&
      (addr1_q[2] <= addr1_q[3]))
    else $error("neighbour addresses out of order");

  // Local parameter never exceeds one
  a_u_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[SA] && (op1_q == crs_pkg::OP_EVAL)) |-> (u1_q <= crs_pkg::U_ONE))
    else $error("local parameter above one");

  // A result appears only from the last lane stage
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(v_q[SL-1]))
    else $error("result without a finished lane item");
`endif

endmodule

/* src/crs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crs_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* src/crs_lane.sv */
// One coordinate lane: Catmull-Rom basis terms and three Horner steps,
// each split into a multiply stage and a round-and-add stage.
// Depends on crs_pkg.
module crs_lane (
  input  logic                               clk_i,
  input  crs_pkg::lane_en_t                  en_i,
  input  logic signed [crs_pkg::COORD_W-1:0] p0_i,
  input  logic signed [crs_pkg::COORD_W-1:0] p1_i,
  input  logic signed [crs_pkg::COORD_W-1:0] p2_i,
  input  logic signed [crs_pkg::COORD_W-1:0] p3_i,
  input  logic [crs_pkg::T_W-1:0]            u_i,
  output crs_pkg::acc_t                      acc_o
);

  // Sign-extend a coordinate to accumulator width
  function automatic crs_pkg::acc_t sx(input logic signed [crs_pkg::COORD_W-1:0] v);
    return {{(crs_pkg::ACC_W-crs_pkg::COORD_W){v[crs_pkg::COORD_W-1]}}, v};
  endfunction

  // Round a Q16 product to nearest, halves upward
  function automatic crs_pkg::acc_t rnd(input crs_pkg::prod_t p);
    crs_pkg::prod_t r;
    r = p + crs_pkg::ROUND_HALF;
    return $signed(r[crs_pkg::ACC_W+crs_pkg::FRAC_W-1:crs_pkg::FRAC_W]);
  endfunction

  crs_pkg::acc_t q0, q1, q2, q3;
  crs_pkg::acc_t e3_d, e2_d, e1_d, e0_d;

  crs_pkg::acc_t e3_q, e2_q, e1_q, e0_q;
  crs_pkg::acc_t e2_4_q, e1_4_q, e0_4_q;
  crs_pkg::acc_t e1_5_q, e0_5_q;
  crs_pkg::acc_t e1_6_q, e0_6_q;
  crs_pkg::acc_t e0_7_q, e0_8_q;
  logic [crs_pkg::T_W-1:0] u3_q, u4_q, u5_q, u6_q, u7_q;
  crs_pkg::prod_t prod4_q, prod6_q, prod8_q;
  crs_pkg::acc_t  a5_q, a7_q, a9_q;

  // Basis terms from the four neighbouring points
  always_comb begin
    q0   = sx(p0_i);
    q1   = sx(p1_i);
    q2   = sx(p2_i);
    q3   = sx(p3_i);
    e3_d = -q0 + (q1 <<< 1) + q1 - (q2 <<< 1) - q2 + q3;
    e2_d = (q0 <<< 1) - (q1 <<< 2) - q1 + (q2 <<< 2) - q3;
    e1_d = q2 - q0;
    e0_d = q1 <<< 1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.terms) begin
      e3_q <= e3_d;
      e2_q <= e2_d;
      e1_q <= e1_d;
      e0_q <= e0_d;
      u3_q <= u_i;
    end
  end

  // First Horner step
  always_ff @(posedge clk_i) begin
    if (en_i.mul1) begin
      prod4_q <= e3_q * $signed({1'b0, u3_q});
      e2_4_q  <= e2_q;
      e1_4_q  <= e1_q;
      e0_4_q  <= e0_q;
      u4_q    <= u3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.add1) begin
      a5_q   <= rnd(prod4_q) + e2_4_q;
      e1_5_q <= e1_4_q;
      e0_5_q <= e0_4_q;
      u5_q   <= u4_q;
    end
  end

  // Second Horner step
  always_ff @(posedge clk_i) begin
    if (en_i.mul2) begin
      prod6_q <= a5_q * $signed({1'b0, u5_q});
      e1_6_q  <= e1_5_q;
      e0_6_q  <= e0_5_q;
      u6_q    <= u5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.add2) begin
      a7_q   <= rnd(prod6_q) + e1_6_q;
      e0_7_q <= e0_6_q;
      u7_q   <= u6_q;
    end
  end

  // Third Horner step
  always_ff @(posedge clk_i) begin
    if (en_i.mul3) begin
      prod8_q <= a7_q * $signed({1'b0, u7_q});
      e0_8_q  <= e0_7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.add3) begin
      a9_q <= rnd(prod8_q) + e0_8_q;
    end
  end

  assign acc_o = a9_q;

endmodule

/* src/crs_merge.sv */
// Merging stage: halves and saturates the three lane sums and registers
// them with the segment index as one result item.
// Depends on crs_pkg.
module crs_merge (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  crs_pkg::acc_t               acc_x_i,
  input  crs_pkg::acc_t               acc_y_i,
  input  crs_pkg::acc_t               acc_z_i,
  input  logic [crs_pkg::IDX_W-1:0]   seg_i,
  output crs_pkg::out_item_t          data_o
);

  localparam int PAD = crs_pkg::ACC_W - crs_pkg::COORD_W;
  localparam crs_pkg::acc_t SAT_HI = {{PAD{1'b0}}, 32'h7FFF_FFFF};
  localparam crs_pkg::acc_t SAT_LO = {{PAD{1'b1}}, 32'h8000_0000};
  localparam crs_pkg::acc_t ONE    = crs_pkg::ACC_W'(1);

  // Halve with rounding upward, then clamp to the signed 32-bit range
  function automatic logic signed [crs_pkg::COORD_W-1:0] half_sat(input crs_pkg::acc_t a);
    crs_pkg::acc_t h;
    h = (a + ONE) >>> 1;
    if (h > SAT_HI) begin
      return SAT_HI[crs_pkg::COORD_W-1:0];
    end else if (h < SAT_LO) begin
      return SAT_LO[crs_pkg::COORD_W-1:0];
    end
    return h[crs_pkg::COORD_W-1:0];
  endfunction

  crs_pkg::out_item_t data_d;

  always_comb begin
    data_d.pos_x   = half_sat(acc_x_i);
    data_d.pos_y   = half_sat(acc_y_i);
    data_d.pos_z   = half_sat(acc_z_i);
    data_d.segment = seg_i;
  end

  // Output register, held while the sink stalls
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o <= data_d;
    end
  end

endmodule
